// ===== hdl/gif_lzw_decoder_macros.svh =====
// Assertion helpers for the GIF LZW decoder.
// Both sample on clk and are disabled while rst is high.
`ifndef GIF_LZW_DECODER_MACROS_SVH
`define GIF_LZW_DECODER_MACROS_SVH

// Same-cycle implication.
`define GLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gld_pkg.sv =====
`default_nettype none
package gld_pkg;

  localparam int CFG_W       = 24;
  localparam int BUF_W       = 24;
  localparam int BCNT_W      = 5;
  localparam int CWID_W      = 4;
  localparam int STACK_BITS  = 12;

  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_LEAD_END = 3'd4;

  localparam logic CFG_MIN_CODE_SIZE = 1'b0;
  localparam logic CFG_PIXEL_COUNT   = 1'b1;

  typedef struct packed {
    logic       start_image;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic       byte_taken;
    logic       pixel_valid;
    logic [7:0] pixel_index;
    logic       pixel_last;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]       min_code_size;
    logic [CFG_W-1:0] pixel_count;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/gld_channels.sv =====
`default_nettype none
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic       start_image;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, start_image, byte_valid, data_byte, stream_end, input ready);
  modport sink   (input valid, start_image, byte_valid, data_byte, stream_end, output ready);
endinterface

interface gld_out_if;
  logic       valid;
  logic       ready;
  logic       byte_taken;
  logic       pixel_valid;
  logic [7:0] pixel_index;
  logic       pixel_last;
  logic [2:0] status;
  modport source (output valid, byte_taken, pixel_valid, pixel_index, pixel_last, status,
                  input ready);
  modport sink   (input valid, byte_taken, pixel_valid, pixel_index, pixel_last, status,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/gld_in_queue.sv =====
`default_nettype none
module gld_in_queue
  import gld_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  gld_in_if.sink    up,
  output in_item_t  head,
  output logic      head_valid,
  input  wire logic pop
);
  // two-entry item queue
  in_item_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign up.ready   = (count != 2'd2);
  assign push       = up.valid && up.ready;
  assign head_valid = (count != 2'd0);
  assign take       = pop && head_valid;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{start_image: up.start_image, byte_valid: up.byte_valid,
                           data_byte: up.data_byte, stream_end: up.stream_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(take);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gld_core.sv =====
`default_nettype none
module gld_core
  import gld_pkg::*;
#(
  parameter int MAX_CODE_BITS    = 12,
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire in_item_t item,
  input  wire logic     item_valid,
  output logic          item_ready,
  output out_item_t     res,
  output logic          res_valid,
  input  wire logic     res_ready
);
  localparam int MCB   = MAX_CODE_BITS;
  localparam int TW    = MCB + 1;
  localparam int PCB   = PIXEL_COUNT_BITS;
  localparam int TSIZE = 1 << MCB;
  localparam int SSIZE = 1 << STACK_BITS;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FETCH, PH_CHAIN, PH_POP, PH_OK, PH_TRUNC, PH_MISMATCH, PH_LEAD_END
  } phase_t;

  phase_t                phase, phase_next;
  logic [STACK_BITS:0]   stack_depth, stack_depth_next;
  logic [TW-1:0]         table_length, table_length_next;
  logic [CWID_W-1:0]     code_width, code_width_next;
  logic [BUF_W-1:0]      bit_buffer, bit_buffer_next;
  logic [BCNT_W-1:0]     bit_count, bit_count_next;
  logic [MCB-1:0]        prev_code, prev_code_next;
  logic [MCB-1:0]        chain_code, chain_code_next;
  logic [7:0]            pending_char, pending_char_next;
  logic [PCB-1:0]        pixels_emitted, pixels_emitted_next;

  // dictionary and stack
  logic [MCB-1:0] prefix_store     [TSIZE];
  logic [7:0]     suffix_store     [TSIZE];
  logic [7:0]     first_char_store [TSIZE];
  logic [7:0]     pixel_stack      [SSIZE];

  logic                  step;
  logic                  dict_we;
  logic [MCB-1:0]        dict_wa;
  logic [MCB-1:0]        dict_pre;
  logic [7:0]            dict_suf;
  logic [7:0]            dict_fc;
  logic                  stk_we;
  logic [STACK_BITS-1:0] stk_wa;
  logic [7:0]            stk_wd;
  logic [MCB-1:0]        fc_ra, chain_ra;
  logic [STACK_BITS-1:0] stk_ra;
  logic [TW-1:0]         mask_next;

  // registered reads with write bypass
  logic [MCB-1:0] pre_q, pre_byp_d;
  logic [7:0]     suf_q, suf_byp_d, fc_q, fc_byp_d, stk_q, stk_byp_d;
  logic           chain_byp, fc_byp, stk_byp;
  logic [MCB-1:0] pre_rd;
  logic [7:0]     suf_rd, fc_rd, stk_rd;

  logic [3:0]     eff_min;
  logic [TW-1:0]  clr, eod, code_mask;
  logic [MCB-1:0] code_now, cv;
  logic [TW-1:0]  cv_w;
  logic [PCB-1:0] limit;
  logic           do_code, do_add, do_push, add_ok;
  logic [MCB-1:0] add_pre;
  logic [7:0]     add_suf, add_fc, push_val, fc_sel;
  logic [TW-1:0]  tl_inc;
  out_item_t      res_next;

  assign step       = item_valid && (!res_valid || res_ready);
  assign item_ready = step;

  assign pre_rd = chain_byp ? pre_byp_d : pre_q;
  assign suf_rd = chain_byp ? suf_byp_d : suf_q;
  assign fc_rd  = fc_byp    ? fc_byp_d  : fc_q;
  assign stk_rd = stk_byp   ? stk_byp_d : stk_q;

  always_comb begin
    if (cfg.min_code_size < 4'd2)      eff_min = 4'd2;
    else if (cfg.min_code_size > 4'd8) eff_min = 4'd8;
    else                               eff_min = cfg.min_code_size;
  end

  assign clr       = TW'(1) << eff_min;
  assign eod       = clr + TW'(1);
  assign limit     = PCB'(cfg.pixel_count);
  assign code_mask = (TW'(1) << code_width) - TW'(1);
  assign code_now  = MCB'(bit_buffer[TW-1:0] & code_mask);
  assign add_ok    = !table_length[MCB];
  assign tl_inc    = table_length + TW'(1);

  always_comb begin
    phase_next          = phase;
    stack_depth_next    = stack_depth;
    table_length_next   = table_length;
    code_width_next     = code_width;
    bit_buffer_next     = bit_buffer;
    bit_count_next      = bit_count;
    prev_code_next      = prev_code;
    chain_code_next     = chain_code;
    pending_char_next   = pending_char;
    pixels_emitted_next = pixels_emitted;
    res_next            = '{byte_taken: 1'b0, pixel_valid: 1'b0, pixel_index: 8'd0,
                            pixel_last: 1'b0, status: ST_BUSY};
    do_code  = 1'b0;
    do_add   = 1'b0;
    do_push  = 1'b0;
    cv       = code_now;
    cv_w     = TW'(code_now);
    add_pre  = prev_code;
    add_suf  = 8'd0;
    add_fc   = 8'd0;
    push_val = 8'd0;
    fc_sel   = 8'd0;
    dict_we  = 1'b0;
    dict_wa  = table_length[MCB-1:0];
    dict_pre = add_pre;
    dict_suf = add_suf;
    dict_fc  = add_fc;
    stk_we   = 1'b0;
    stk_wa   = stack_depth[STACK_BITS-1:0];
    stk_wd   = push_val;

    if (item.start_image) begin
      table_length_next   = clr + TW'(2);
      code_width_next     = eff_min + 4'd1;
      prev_code_next      = MCB'(clr);
      stack_depth_next    = '0;
      bit_buffer_next     = '0;
      bit_count_next      = '0;
      chain_code_next     = '0;
      pending_char_next   = '0;
      pixels_emitted_next = '0;
      phase_next          = PH_FETCH;
    end else begin
      case (phase)
        PH_FETCH: begin
          if (bit_count >= BCNT_W'(code_width)) begin
            bit_buffer_next = bit_buffer >> code_width;
            bit_count_next  = bit_count - BCNT_W'(code_width);
            do_code         = 1'b1;
          end else if (item.byte_valid) begin
            bit_buffer_next     = bit_buffer | (BUF_W'(item.data_byte) << bit_count);
            bit_count_next      = bit_count + BCNT_W'(8);
            res_next.byte_taken = 1'b1;
          end else if (item.stream_end) begin
            if (bit_count != '0) begin
              bit_buffer_next = '0;
              bit_count_next  = '0;
              do_code         = 1'b1;
            end else begin
              phase_next = PH_TRUNC;
            end
          end
          if (do_code) begin
            if (cv_w == clr) begin
              table_length_next = clr + TW'(2);
              code_width_next   = eff_min + 4'd1;
              prev_code_next    = MCB'(clr);
            end else if (cv_w == eod) begin
              if (TW'(prev_code) == clr && pixels_emitted == '0) phase_next = PH_LEAD_END;
              else if (pixels_emitted == limit)                 phase_next = PH_OK;
              else                                              phase_next = PH_MISMATCH;
            end else if (TW'(prev_code) == clr) begin
              if (cv_w < clr) begin
                chain_code_next   = cv;
                prev_code_next    = cv;
                pending_char_next = cv[7:0];
                phase_next        = PH_CHAIN;
              end
            end else if (cv_w < table_length) begin
              fc_sel            = (cv_w < clr) ? cv[7:0] : fc_rd;
              do_add            = 1'b1;
              add_suf           = fc_sel;
              add_fc            = pending_char;
              pending_char_next = fc_sel;
              prev_code_next    = cv;
              chain_code_next   = cv;
              phase_next        = PH_CHAIN;
            end else begin
              // code not yet in table: previous string plus its own first char
              do_push         = 1'b1;
              push_val        = pending_char;
              chain_code_next = prev_code;
              do_add          = 1'b1;
              add_suf         = pending_char;
              add_fc          = pending_char;
              if (add_ok) prev_code_next = table_length[MCB-1:0];
              phase_next      = PH_CHAIN;
            end
          end
        end
        PH_CHAIN: begin
          if (stack_depth[STACK_BITS]) begin
            phase_next = PH_POP;
          end else if (TW'(chain_code) < clr) begin
            do_push    = 1'b1;
            push_val   = chain_code[7:0];
            phase_next = PH_POP;
          end else begin
            do_push         = 1'b1;
            push_val        = suf_rd;
            chain_code_next = pre_rd;
          end
        end
        PH_POP: begin
          if (stack_depth == '0) begin
            phase_next = PH_FETCH;
          end else begin
            stack_depth_next = stack_depth - 1'b1;
            if (pixels_emitted >= limit) begin
              phase_next = PH_MISMATCH;
            end else begin
              pixels_emitted_next  = pixels_emitted + 1'b1;
              res_next.pixel_valid = 1'b1;
              res_next.pixel_index = stk_rd;
              res_next.pixel_last  = (pixels_emitted + 1'b1) == limit;
              if (stack_depth == (STACK_BITS+1)'(1)) phase_next = PH_FETCH;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_add && add_ok) begin
      dict_we           = 1'b1;
      dict_pre          = add_pre;
      dict_suf          = add_suf;
      dict_fc           = add_fc;
      table_length_next = tl_inc;
      if (tl_inc == (TW'(1) << code_width) && code_width < CWID_W'(MCB))
        code_width_next = code_width + 4'd1;
    end
    if (do_push && !stack_depth[STACK_BITS]) begin
      stk_we           = 1'b1;
      stk_wd           = push_val;
      stack_depth_next = stack_depth + 1'b1;
    end

    case (phase_next)
      PH_OK:       res_next.status = ST_OK;
      PH_TRUNC:    res_next.status = ST_TRUNC;
      PH_MISMATCH: res_next.status = ST_MISMATCH;
      PH_LEAD_END: res_next.status = ST_LEAD_END;
      default:     res_next.status = ST_BUSY;
    endcase
  end

  // read addresses follow the state the next item will see
  assign mask_next = (TW'(1) << code_width_next) - TW'(1);
  assign fc_ra     = MCB'(bit_buffer_next[TW-1:0] & mask_next);
  assign chain_ra  = chain_code_next;
  assign stk_ra    = STACK_BITS'(stack_depth_next - 1'b1);

  always_ff @(posedge clk) begin
    if (step) begin
      if (dict_we) begin
        prefix_store[dict_wa]     <= dict_pre;
        suffix_store[dict_wa]     <= dict_suf;
        first_char_store[dict_wa] <= dict_fc;
      end
      pre_q     <= prefix_store[chain_ra];
      suf_q     <= suffix_store[chain_ra];
      fc_q      <= first_char_store[fc_ra];
      chain_byp <= dict_we && (dict_wa == chain_ra);
      fc_byp    <= dict_we && (dict_wa == fc_ra);
      pre_byp_d <= dict_pre;
      suf_byp_d <= dict_suf;
      fc_byp_d  <= dict_fc;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (stk_we) pixel_stack[stk_wa] <= stk_wd;
      stk_q     <= pixel_stack[stk_ra];
      stk_byp   <= stk_we && (stk_wa == stk_ra);
      stk_byp_d <= stk_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stack_depth    <= '0;
      table_length   <= '0;
      code_width     <= CWID_W'(9);
      bit_buffer     <= '0;
      bit_count      <= '0;
      prev_code      <= '0;
      chain_code     <= '0;
      pending_char   <= '0;
      pixels_emitted <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (step) begin
        phase          <= phase_next;
        stack_depth    <= stack_depth_next;
        table_length   <= table_length_next;
        code_width     <= code_width_next;
        bit_buffer     <= bit_buffer_next;
        bit_count      <= bit_count_next;
        prev_code      <= prev_code_next;
        chain_code     <= chain_code_next;
        pending_char   <= pending_char_next;
        pixels_emitted <= pixels_emitted_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= res_next;
  end
endmodule
`default_nettype wire

// ===== hdl/gif_lzw_decoder.sv =====
`default_nettype none
// Channel   Dir  Carries
// data_in   in   one tick: start_image, byte_valid, data_byte, stream_end
// pix_out   out  one result per tick: byte_taken, pixel, pixel_last, status
// cfg       in   write-only registers: 0 min_code_size, 1 pixel_count
//
// One item per clock when pix_out is ready; an item's result is written to the
// output register at the same edge that takes it from the two-entry input queue.
// Dictionary and stack reads are registered and addressed from the next state.
// Synchronous reset clears control; the stores are not cleared.
// A stalled pix_out holds its item; the queue keeps taking items until full.
`include "gif_lzw_decoder_macros.svh"
module gif_lzw_decoder
  import gld_pkg::*;
#(
  parameter int MAX_CODE_BITS    = 12,
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  gld_in_if.sink                data_in,
  gld_out_if.source             pix_out
);
  cfg_t      cfg;
  in_item_t  head;
  logic      head_valid;
  logic      head_pop;
  out_item_t res;
  logic      res_valid;

  // configuration registers, used live by the core
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_code_size <= 4'd8;
      cfg.pixel_count   <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_CODE_SIZE: cfg.min_code_size <= cfg_data[3:0];
        CFG_PIXEL_COUNT:   cfg.pixel_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: item queue
  gld_in_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .up         (data_in),
    .head       (head),
    .head_valid (head_valid),
    .pop        (head_pop)
  );

  // back: unpack, dictionary, stack and output register
  gld_core #(
    .MAX_CODE_BITS    (MAX_CODE_BITS),
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (head),
    .item_valid (head_valid),
    .item_ready (head_pop),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (pix_out.ready)
  );

  assign pix_out.valid       = res_valid;
  assign pix_out.byte_taken  = res.byte_taken;
  assign pix_out.pixel_valid = res.pixel_valid;
  assign pix_out.pixel_index = res.pixel_index;
  assign pix_out.pixel_last  = res.pixel_last;
  assign pix_out.status      = res.status;

  `GLD_ASSERT_NOW(a_last_has_pixel, pix_out.valid && pix_out.pixel_last, pix_out.pixel_valid, "pixel_last without pixel")
  `GLD_ASSERT_NOW(a_byte_or_pixel, pix_out.valid && pix_out.byte_taken, !pix_out.pixel_valid, "byte and pixel in one item")
  `GLD_ASSERT_NOW(a_pixel_busy, pix_out.valid && pix_out.pixel_valid, pix_out.status == ST_BUSY, "pixel with final status")
endmodule
`default_nettype wire

// ===== tb/gld_checker.sv =====
`timescale 1ns / 1ps
module gld_checker
  import gld_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  gld_in_if                in_ch,
  gld_out_if               out_ch,
  output int               errors,
  output int               outstanding,
  output logic             byte_wanted,
  output logic             image_over
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FETCH, PH_CHAIN, PH_POP, PH_OK, PH_TRUNC, PH_MISM, PH_LEAD
  } phase_t;

  localparam int DICT_SIZE = 4096;

  logic [11:0] prefix_mem [DICT_SIZE];
  logic [7:0]  suffix_mem [DICT_SIZE];
  logic [7:0]  first_mem  [DICT_SIZE];
  logic [7:0]  stack_mem  [DICT_SIZE];

  logic [12:0] depth, table_len;
  logic [3:0]  code_w;
  logic [23:0] bit_buf;
  logic [4:0]  bit_cnt;
  logic [11:0] prev_code, chain;
  logic [7:0]  pend_char;
  logic [23:0] emitted;
  phase_t      phase;
  logic [3:0]  min_cs;
  logic [23:0] pix_cnt;

  out_item_t   pixel_q [$];

  function automatic int unsigned clear_code();
    int unsigned m;
    m = (min_cs < 2) ? 2 : (min_cs > 8) ? 8 : min_cs;
    return 1 << m;
  endfunction

  task automatic end_image(input logic [2:0] st);
    phase = phase_t'(PH_POP + st);
  endtask

  task automatic push_px(input logic [7:0] v);
    if (depth < DICT_SIZE) begin
      stack_mem[depth[11:0]] = v;
      depth++;
    end
  endtask

  task automatic reset_dict();
    int unsigned clr;
    clr = clear_code();
    table_len = 13'(clr + 2);
    code_w = 4'($clog2(clr) + 1);
    prev_code = 12'(clr);
  endtask

  task automatic grow(input logic [11:0] pre, input logic [7:0] suf, input logic [7:0] fc,
                      output bit added);
    added = 0;
    if (table_len < DICT_SIZE) begin
      prefix_mem[table_len[11:0]] = pre;
      suffix_mem[table_len[11:0]] = suf;
      first_mem[table_len[11:0]]  = fc;
      table_len++;
      if (table_len == (13'd1 << code_w) && code_w < 12) code_w++;
      added = 1;
    end
  endtask

  task automatic decode_code(input int unsigned c);
    int unsigned clr;
    logic [7:0]  fc, k;
    logic [12:0] idx;
    bit          added;
    clr = clear_code();
    if (c == clr) begin
      reset_dict();
      return;
    end
    if (c == clr + 1) begin
      if (prev_code == clr && emitted == 0) end_image(ST_LEAD_END);
      else end_image((emitted == pix_cnt) ? ST_OK : ST_MISMATCH);
      return;
    end
    if (prev_code == clr) begin
      // first code after a clear: roots only, anything else is skipped
      if (c < clr) begin
        chain = 12'(c);
        prev_code = 12'(c);
        pend_char = 8'(c);
        phase = PH_CHAIN;
      end
      return;
    end
    if (c < table_len) begin
      fc = (c < clr) ? 8'(c) : first_mem[c];
      grow(prev_code, fc, pend_char, added);
      pend_char = fc;
      prev_code = 12'(c);
      chain = 12'(c);
    end else begin
      // code not in table yet: previous string plus its own first char
      k = pend_char;
      idx = table_len;
      push_px(k);
      chain = prev_code;
      grow(prev_code, k, k, added);
      if (added) prev_code = idx[11:0];
    end
    phase = PH_CHAIN;
  endtask

  task automatic decode_tick(input in_item_t it, output out_item_t res);
    int unsigned clr, mask;
    res = '0;
    clr = clear_code();
    if (it.start_image) begin
      reset_dict();
      depth = 0; bit_buf = 0; bit_cnt = 0;
      chain = 0; pend_char = 0; emitted = 0;
      phase = PH_FETCH;
    end else if (phase == PH_FETCH) begin
      mask = (1 << code_w) - 1;
      if (bit_cnt >= code_w) begin
        // shift by the width the code was read at, then decode
        mask = bit_buf & mask;
        bit_buf = bit_buf >> code_w;
        bit_cnt = bit_cnt - 5'(code_w);
        decode_code(mask);
      end else if (it.byte_valid) begin
        bit_buf = bit_buf | (24'(it.data_byte) << bit_cnt);
        bit_cnt = bit_cnt + 5'd8;
        res.byte_taken = 1'b1;
      end else if (it.stream_end) begin
        if (bit_cnt > 0) begin
          // last code padded with zero bits
          mask = bit_buf & mask;
          bit_buf = 0;
          bit_cnt = 0;
          decode_code(mask);
        end else begin
          end_image(ST_TRUNC);
        end
      end
    end else if (phase == PH_CHAIN) begin
      if (depth >= DICT_SIZE) begin
        phase = PH_POP;
      end else if (chain < clr) begin
        push_px(chain[7:0]);
        phase = PH_POP;
      end else begin
        push_px(suffix_mem[chain]);
        chain = prefix_mem[chain];
      end
    end else if (phase == PH_POP) begin
      if (depth == 0) begin
        phase = PH_FETCH;
      end else begin
        depth--;
        if (emitted >= pix_cnt) begin
          end_image(ST_MISMATCH);
        end else begin
          res.pixel_valid = 1'b1;
          res.pixel_index = stack_mem[depth[11:0]];
          emitted++;
          res.pixel_last = (emitted == pix_cnt);
          if (depth == 0) phase = PH_FETCH;
        end
      end
    end
    res.status = (phase > PH_POP) ? 3'(phase - PH_POP) : ST_BUSY;
  endtask

  always @(posedge clk) begin
    in_item_t  it;
    out_item_t want, got;
    if (rst) begin
      depth = 0; table_len = 0; code_w = 9; bit_buf = 0; bit_cnt = 0;
      prev_code = 0; chain = 0; pend_char = 0; emitted = 0; phase = PH_IDLE;
      min_cs = 8; pix_cnt = 1;
      pixel_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_CODE_SIZE) min_cs = cfg_data[3:0];
        else pix_cnt = cfg_data[23:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        it = '{in_ch.start_image, in_ch.byte_valid, in_ch.data_byte, in_ch.stream_end};
        decode_tick(it, want);
        pixel_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.byte_taken, out_ch.pixel_valid, out_ch.pixel_index,
                out_ch.pixel_last, out_ch.status};
        if (pixel_q.size() == 0) begin
          if (errors < 10) $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("%0t: result mismatch exp taken=%b pv=%b pix=%h last=%b st=%0d, got taken=%b pv=%b pix=%h last=%b st=%0d",
                       $time, want.byte_taken, want.pixel_valid, want.pixel_index,
                       want.pixel_last, want.status, got.byte_taken, got.pixel_valid,
                       got.pixel_index, got.pixel_last, got.status);
            errors <= errors + 1;
          end
        end
      end
    end
    outstanding <= pixel_q.size();
    byte_wanted <= (phase == PH_FETCH) && (bit_cnt < code_w);
    image_over  <= (phase > PH_POP);
  end

endmodule

// ===== tb/gif_lzw_decoder_tb.sv =====
`timescale 1ns / 1ps
module gif_lzw_decoder_tb;
  import gld_pkg::*;

  // image flavors
  localparam int IMG_NORMAL = 0;
  localparam int IMG_TRUNC  = 1;
  localparam int IMG_LEAD   = 2;
  localparam int IMG_FILL   = 3;
  // how pixel_count relates to the true pixel total
  localparam int PC_EXACT = 0;
  localparam int PC_NEAR  = 1;
  localparam int PC_MAX   = 2;
  localparam int PC_ONE   = 3;

  localparam int CYCLE_LIMIT = 1500000;

  logic             clk, rst;
  logic             cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gld_in_if  in_ch ();
  gld_out_if out_ch ();

  int   fail_cnt, pend_cnt;
  logic byte_wanted, image_over;

  int   in_idle_pct, out_stall_pct;
  bit   hold_request, hold_taken;
  int   hold_left;
  int   cycles;
  int   ticks_sent;

  // code stream under construction, LSB first
  logic [7:0]  code_bytes [$];
  logic [31:0] pack_acc;
  int          pack_bits;
  int          str_len [4096];

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .data_in(in_ch), .pix_out(out_ch)
  );

  gld_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch),
    .errors(fail_cnt), .outstanding(pend_cnt),
    .byte_wanted(byte_wanted), .image_over(image_over)
  );

  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0; cfg_index = CFG_MIN_CODE_SIZE; cfg_data = '0;
    in_ch.valid = 0; in_ch.start_image = 0; in_ch.byte_valid = 0;
    in_ch.data_byte = '0; in_ch.stream_end = 0;
    out_ch.ready = 0;
    in_idle_pct = 0; out_stall_pct = 0;
    hold_request = 0; hold_taken = 0; hold_left = 0;
    cycles = 0; ticks_sent = 0;
  end

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off once asked for
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1;
      hold_left <= 400;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= !(out_stall_pct > 0 && $urandom_range(99) < out_stall_pct);
    end
  end

  // one tick item, held until the block takes it
  task automatic send_tick(input logic st, input logic bv, input logic [7:0] db,
                           input logic se);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid       <= 1;
    in_ch.start_image <= st;
    in_ch.byte_valid  <= bv;
    in_ch.data_byte   <= db;
    in_ch.stream_end  <= se;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic put_code(input int c, input int w);
    pack_acc = pack_acc | (32'(c) << pack_bits);
    pack_bits += w;
    while (pack_bits >= 8) begin
      code_bytes.push_back(pack_acc[7:0]);
      pack_acc = pack_acc >> 8;
      pack_bits -= 8;
    end
  endtask

  // Builds a code stream while tracking the table the way the decoder grows it,
  // so widths match and the pixel total is known.
  task automatic build_stream(input int kind, input int n_codes, input logic [3:0] mcs,
                              output int pixels);
    int m, clr, tl, w, prv, c, r;
    bit first;
    m = (mcs < 2) ? 2 : (mcs > 8) ? 8 : mcs;
    clr = 1 << m;
    tl = clr + 2; w = m + 1; prv = clr; first = 1; pixels = 0;
    pack_acc = 0; pack_bits = 0;
    code_bytes.delete();
    if (kind != IMG_FILL && $urandom_range(2) == 0) put_code(clr, w);
    for (int i = 0; i < n_codes && kind != IMG_LEAD; i++) begin
      r = $urandom_range(99);
      if (kind == IMG_FILL) c = $urandom_range(clr - 1);
      else if (first) c = (r < 10) ? $urandom_range(clr + 2, (1 << w) - 1)
                                   : $urandom_range(clr - 1);
      else if (r < 4) c = clr;
      else if (r < 12 && tl < (1 << w)) c = tl;
      else if (r < 16) c = $urandom_range(tl, (1 << w) - 1);
      else begin
        c = $urandom_range(tl - 1);
        if (c == clr || c == clr + 1) c = $urandom_range(clr - 1);
      end
      put_code(c, w);
      if (c == clr) begin
        tl = clr + 2; w = m + 1; first = 1;
      end else if (first) begin
        if (c < clr) begin
          first = 0; prv = c; pixels += 1;
        end
      end else begin
        pixels += (c < tl) ? str_len[c] : str_len[prv] + 1;
        if (tl < 4096) begin
          str_len[tl] = str_len[prv] + 1;
          if (c >= tl) prv = tl;
          tl++;
          if (tl == (1 << w) && w < 12) w++;
        end
        if (c < tl - 1 || (c < tl && tl == 4096)) prv = c;
      end
    end
    if (kind != IMG_TRUNC) put_code(clr + 1, w);
    if (pack_bits > 0) code_bytes.push_back(pack_acc[7:0] | 8'($urandom << pack_bits));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    do @(posedge clk); while (pend_cnt != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_image(input int kind, input int n_codes, input logic [3:0] mcs,
                           input int pc_mode);
    int pixels, ptr, guard;
    logic [23:0] pc;
    logic bv;
    wait_drained();
    build_stream(kind, n_codes, mcs, pixels);
    case (pc_mode)
      PC_EXACT: pc = (pixels > 0) ? 24'(pixels) : 24'd1;
      PC_NEAR: pc = (pixels > 2) ? 24'(pixels + $urandom_range(4) - 2) : 24'd1;
      PC_MAX: pc = 24'hFFFFFF;
      default: pc = 24'd1;
    endcase
    // registers change only while the decoder sits idle
    @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_MIN_CODE_SIZE; cfg_data <= CFG_W'(mcs);
    @(posedge clk);
    cfg_index <= CFG_PIXEL_COUNT; cfg_data <= pc;
    @(posedge clk);
    cfg_we <= 0;
    send_tick(1, $urandom_range(1), 8'($urandom), $urandom_range(1));
    ptr = 0; guard = 0;
    while (!image_over && guard < 100000) begin
      bv = (ptr < code_bytes.size()) && ($urandom_range(7) != 0);
      send_tick(0, bv, bv ? code_bytes[ptr] : 8'($urandom),
                (ptr >= code_bytes.size()) || (bv && $urandom_range(1)));
      if (bv && byte_wanted) ptr++;
      guard++;
    end
    // a few ticks while the final status is held
    repeat ($urandom_range(3))
      send_tick(0, $urandom_range(1), 8'($urandom), $urandom_range(1));
  endtask

  initial begin
    int kind;
    for (int i = 0; i < 256; i++) str_len[i] = 1;
    repeat (5) @(posedge clk);
    rst <= 0;

    // ticks before any start are ignored
    repeat (3) send_tick(0, 1, 8'($urandom), $urandom_range(1));

    // directed: widths, config extremes, each ending
    run_image(IMG_NORMAL, 6, 4'd8, PC_EXACT);
    run_image(IMG_NORMAL, 12, 4'd2, PC_EXACT);
    run_image(IMG_LEAD, 0, 4'd4, PC_EXACT);
    run_image(IMG_TRUNC, 8, 4'd3, PC_EXACT);
    run_image(IMG_NORMAL, 5, 4'd15, PC_EXACT);
    run_image(IMG_NORMAL, 5, 4'd0, PC_EXACT);
    run_image(IMG_NORMAL, 5, 4'd1, PC_NEAR);
    run_image(IMG_NORMAL, 6, 4'd5, PC_MAX);
    run_image(IMG_NORMAL, 6, 4'd7, PC_ONE);

    // random images across idle / stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 13) : 0;
      out_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 13 : 0;
      if (ph == 0) hold_request = 1;
      ticks_sent = 0;
      while (ticks_sent < 100) begin
        kind = $urandom_range(19);
        kind = (kind < 16) ? IMG_NORMAL : (kind < 19) ? IMG_TRUNC : IMG_LEAD;
        run_image(kind, $urandom_range(1, 20), 4'($urandom_range(2, 8)),
                  ($urandom_range(4) == 0) ? PC_NEAR : PC_EXACT);
      end
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
